// ===== src/bfm_pkg.sv =====
// Shared types and constants of the boolean function minimizer.
package bfm_pkg;

	// Configuration register indexes.
	localparam logic CFG_VAR_COUNT    = 1'b0;
	localparam logic CFG_USE_MINTERMS = 1'b1;

	// Largest number of cover terms emitted for one table.
	localparam int MAX_RESULTS = 16;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic sel;          // which work RAM holds the current list
		logic row_wr;       // store one truth table row
		logic terms_ld;     // table finished, latch the term set
		logic fill_we;      // write a full-width implicant for the current row
		logic used_we;      // write a merge flag
		logic used_wd;      // value of that merge flag
		logic a_ld;         // hold the work entry just read
		logic g_ld;         // hold the merged implicant
		logic next_we;      // append the merged implicant to the next list
		logic prime_we;     // append the held entry to the prime list
		logic cnt_clr;      // clear the essential-prime hit count
		logic ess_hit;      // a prime covers the current row
		logic cand_last;    // candidate comes from the only covering prime
		logic cand_best;    // candidate comes from the best greedy prime
		logic cover_we;     // write the cover RAM
		logic cover_shift;  // cover write data is the entry just read
		logic cov_clr;      // clear the covered row set
		logic best_clr;     // start a greedy search
		logic best_try;     // compare one prime in the greedy search
		logic oth_clr;      // clear the rows covered by the other terms
		logic oth_or;       // add the rows of the cover entry just read
		logic out_ld;       // load the output register
		logic out_empty;    // the loaded result marks an empty cover
		logic out_last;     // the loaded result ends the cover
	} bfm_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic merge_ok;     // held entry and entry read differ in one literal
		logic next_eq;      // next-list entry read equals the merged implicant
		logic a_used;       // held entry merged at least once
		logic used_bit;     // merge flag read
		logic prime_eq;     // prime read equals the held entry
		logic p_covers;     // prime read covers the current row
		logic cover_eq;     // cover entry read equals the candidate
		logic term_bit;     // current row is a term
		logic covered_bit;  // current row is already covered
		logic redundant;    // other cover terms cover every term
		logic cnt_one;      // exactly one prime covers the current row
		logic have_best;    // the greedy search found a prime
		logic out_fire;     // output transaction completes
	} bfm_stat_t;

endpackage

// ===== src/bfm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bfm_dp.sv =====
// Datapath of the minimizer: implicant RAMs, row sets, compare logic and output register.
module bfm_dp import bfm_pkg::*; #(
	parameter int MAX_VARS = 5,
	parameter int TABLE_DEPTH = 64,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int RW = MAX_VARS + 1,
	localparam int IW = 2 * MAX_VARS,
	localparam int R = 1 << MAX_VARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bfm_cmd_t            cmd,
	input  logic [2:0]          n_eff,
	input  logic                use_minterms,
	input  logic                row_value,
	input  logic [RW-1:0]       row_idx,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	output bfm_stat_t           stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [MAX_VARS-1:0] out_mask,
	output logic [MAX_VARS-1:0] out_value,
	output logic                out_empty,
	output logic                out_last
);

	// Rows of an implicant {mask, value} inside the current table.
	function automatic logic [R-1:0] cov_rows(input logic [IW-1:0] x,
			input logic [RW-1:0] rws);
		logic [R-1:0] bits;
		bits = '0;
		for (int k = 0; k < R; k++) begin
			bits[k] = (((MAX_VARS'(k) ^ x[MAX_VARS-1:0]) & x[IW-1:MAX_VARS]) == '0)
				&& (RW'(k) < rws);
		end
		return bits;
	endfunction

	logic [RW-1:0]       rows;
	logic [MAX_VARS-1:0] full_mask;
	logic [R-1:0]        row_mask;
	logic [R-1:0]        term_bm_q;
	logic [R-1:0]        bm_next;
	logic [R-1:0]        terms_q;
	logic [R-1:0]        covered_q;
	logic [R-1:0]        others_q;

	logic [IW-1:0] x0_rd, x1_rd, x_wd, work_rd, next_rd, prime_rd, cover_rd, cover_wd;
	logic          x0_we, x1_we, used_rd;

	logic [IW-1:0]       a_q, g_q, last_q, cand_q, best_q, g_new;
	logic                a_used_q, have_best_q;
	logic [1:0]          cnt_q;
	logic [RW-1:0]       best_n_q, gain;
	logic [MAX_VARS-1:0] am, av, wm, wv, diff, rbits;

	logic                out_valid_q, out_empty_q, out_last_q;
	logic [MAX_VARS-1:0] out_mask_q, out_value_q;

	// Table geometry from the variable count.
	always_comb begin
		rows = RW'(1) << n_eff;
		full_mask = '0;
		for (int k = 0; k < MAX_VARS; k++) begin
			full_mask[k] = (3'(k) < n_eff);
		end
		row_mask = '0;
		for (int k = 0; k < R; k++) begin
			row_mask[k] = (RW'(k) < rows);
		end
	end

	assign bm_next = term_bm_q | (R'(row_value) << row_idx[MAX_VARS-1:0]);
	assign rbits = row_idx[MAX_VARS-1:0];

	// Row collection and term set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_bm_q <= '0;
		end else if (cmd.row_wr) begin
			term_bm_q <= cmd.terms_ld ? '0 : bm_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_wr && cmd.terms_ld) begin
			terms_q <= (use_minterms ? bm_next : ~bm_next) & row_mask;
		end
	end

	// Ping-pong work lists: one holds the current pass, the other collects merges.
	assign x_wd  = cmd.fill_we ? {full_mask, rbits} : g_q;
	assign x0_we = (cmd.fill_we && !cmd.sel) || (cmd.next_we && cmd.sel);
	assign x1_we = (cmd.fill_we && cmd.sel) || (cmd.next_we && !cmd.sel);

	bfm_ram #(.WIDTH(IW), .DEPTH(TABLE_DEPTH)) u_x0 (
		.clk(clk), .we(x0_we), .waddr(wr_addr), .wdata(x_wd),
		.raddr(rd_addr), .rdata(x0_rd));

	bfm_ram #(.WIDTH(IW), .DEPTH(TABLE_DEPTH)) u_x1 (
		.clk(clk), .we(x1_we), .waddr(wr_addr), .wdata(x_wd),
		.raddr(rd_addr), .rdata(x1_rd));

	bfm_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
		.clk(clk), .we(cmd.used_we), .waddr(wr_addr), .wdata(cmd.used_wd),
		.raddr(rd_addr), .rdata(used_rd));

	bfm_ram #(.WIDTH(IW), .DEPTH(TABLE_DEPTH)) u_prime (
		.clk(clk), .we(cmd.prime_we), .waddr(wr_addr), .wdata(a_q),
		.raddr(rd_addr), .rdata(prime_rd));

	assign cover_wd = cmd.cover_shift ? cover_rd : cand_q;

	bfm_ram #(.WIDTH(IW), .DEPTH(TABLE_DEPTH)) u_cover (
		.clk(clk), .we(cmd.cover_we), .waddr(wr_addr), .wdata(cover_wd),
		.raddr(rd_addr), .rdata(cover_rd));

	assign work_rd = cmd.sel ? x1_rd : x0_rd;
	assign next_rd = cmd.sel ? x0_rd : x1_rd;

	// Merge test: equal masks, values differ in exactly one masked bit.
	always_comb begin
		am = a_q[IW-1:MAX_VARS];
		av = a_q[MAX_VARS-1:0];
		wm = work_rd[IW-1:MAX_VARS];
		wv = work_rd[MAX_VARS-1:0];
		diff = (av ^ wv) & am;
		g_new = {am & ~diff, av & ~diff};
	end

	assign gain = RW'($countones(cov_rows(prime_rd, rows) & ~covered_q));

	// Held operands of the merge and covering loops.
	always_ff @(posedge clk) begin
		if (cmd.a_ld) begin
			a_q <= work_rd;
		end
		if (cmd.g_ld) begin
			g_q <= g_new;
		end
		if (cmd.ess_hit) begin
			last_q <= prime_rd;
		end
		if (cmd.best_try && gain > best_n_q) begin
			best_q <= prime_rd;
		end
		if (cmd.cand_last) begin
			cand_q <= last_q;
		end else if (cmd.cand_best) begin
			cand_q <= best_q;
		end
		if (cmd.oth_clr) begin
			others_q <= '0;
		end else if (cmd.oth_or) begin
			others_q <= others_q | cov_rows(cover_rd, rows);
		end
		if (cmd.cov_clr) begin
			covered_q <= '0;
		end else if (cmd.cover_we && !cmd.cover_shift) begin
			covered_q <= covered_q | cov_rows(cand_q, rows);
		end
	end

	// Loop flags and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_used_q    <= 1'b0;
			cnt_q       <= '0;
			have_best_q <= 1'b0;
			best_n_q    <= '0;
		end else begin
			if (cmd.a_ld) begin
				a_used_q <= 1'b0;
			end else if (cmd.g_ld) begin
				a_used_q <= 1'b1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.ess_hit && cnt_q != 2'd2) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (cmd.best_clr) begin
				have_best_q <= 1'b0;
				best_n_q    <= '0;
			end else if (cmd.best_try && gain > best_n_q) begin
				have_best_q <= 1'b1;
				best_n_q    <= gain;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_mask_q  <= cmd.out_empty ? '0 : cover_rd[IW-1:MAX_VARS];
			out_value_q <= cmd.out_empty ? '0 : cover_rd[MAX_VARS-1:0];
			out_empty_q <= cmd.out_empty;
			out_last_q  <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_mask  = out_mask_q;
	assign out_value = out_value_q;
	assign out_empty = out_empty_q;
	assign out_last  = out_last_q;

	// Status to the sequencer.
	always_comb begin
		stat.merge_ok    = (am == wm) && (diff != '0) && ((diff & (diff - MAX_VARS'(1))) == '0);
		stat.next_eq     = (next_rd == g_q);
		stat.a_used      = a_used_q;
		stat.used_bit    = used_rd;
		stat.prime_eq    = (prime_rd == a_q);
		stat.p_covers    = (((rbits ^ prime_rd[MAX_VARS-1:0]) & prime_rd[IW-1:MAX_VARS]) == '0);
		stat.cover_eq    = (cover_rd == cand_q);
		stat.term_bit    = terms_q[rbits];
		stat.covered_bit = covered_q[rbits];
		stat.redundant   = ((terms_q & ~others_q) == '0);
		stat.cnt_one     = (cnt_q == 2'd1);
		stat.have_best   = have_best_q;
		stat.out_fire    = out_valid_q && out_ready;
	end

endmodule

// ===== src/bfm_ctrl.sv =====
// Sequencer of the minimizer: configuration, loop counters and the phase state machine.
module bfm_ctrl import bfm_pkg::*; #(
	parameter int MAX_VARS = 5,
	parameter int TABLE_DEPTH = 64,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = AW + 1,
	localparam int RW = MAX_VARS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [2:0]    cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  bfm_stat_t     stat,
	output bfm_cmd_t      cmd,
	output logic [2:0]    n_eff,
	output logic          use_minterms,
	output logic [RW-1:0] row_idx,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_addr
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_FILL  = 5'd1;
	localparam logic [4:0] S_CLR   = 5'd2;
	localparam logic [4:0] S_A     = 5'd3;
	localparam logic [4:0] S_B     = 5'd4;
	localparam logic [4:0] S_DUP   = 5'd5;
	localparam logic [4:0] S_AEND  = 5'd6;
	localparam logic [4:0] S_PR    = 5'd7;
	localparam logic [4:0] S_PDUP  = 5'd8;
	localparam logic [4:0] S_COVI  = 5'd9;
	localparam logic [4:0] S_ESS   = 5'd10;
	localparam logic [4:0] S_ESSP  = 5'd11;
	localparam logic [4:0] S_ADD   = 5'd12;
	localparam logic [4:0] S_GR    = 5'd13;
	localparam logic [4:0] S_GRP   = 5'd14;
	localparam logic [4:0] S_RED   = 5'd15;
	localparam logic [4:0] S_REDC  = 5'd16;
	localparam logic [4:0] S_SHIFT = 5'd17;
	localparam logic [4:0] S_EMIT  = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [4:0]    state_q;
	logic          ph_q, sel_q, ret_q, um_q;
	logic [2:0]    vc_q;
	logic [RW-1:0] row_cnt_q, r_q, rows;
	logic [CW-1:0] a_q, b_q, j_q, p_q, i_q, wc_q, nc_q, pc_q, cc_q, j_inc;
	logic          in_fire, row_last, last_e;

	// Effective variable count and table size.
	always_comb begin
		if (vc_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (vc_q > 3'(MAX_VARS)) begin
			n_eff = 3'(MAX_VARS);
		end else begin
			n_eff = vc_q;
		end
	end

	assign rows         = RW'(1) << n_eff;
	assign use_minterms = um_q;
	assign in_ready     = (state_q == S_LOAD);
	assign in_fire      = in_valid && in_ready;
	assign row_last     = (row_cnt_q + RW'(1)) >= rows;
	assign j_inc        = j_q + CW'(1);
	assign last_e       = (cc_q == '0) || (i_q + CW'(1) == cc_q)
		|| (i_q == CW'(MAX_RESULTS - 1));
	assign row_idx      = (state_q == S_LOAD) ? row_cnt_q : r_q;

	// RAM addresses for the loop being run.
	always_comb begin
		case (state_q)
			S_A, S_PR:                     rd_addr = AW'(a_q);
			S_B:                           rd_addr = AW'(b_q);
			S_DUP, S_PDUP, S_ADD, S_REDC:  rd_addr = AW'(j_q);
			S_ESSP, S_GRP:                 rd_addr = AW'(p_q);
			S_SHIFT:                       rd_addr = AW'(j_inc);
			S_EMIT:                        rd_addr = AW'(i_q);
			default:                       rd_addr = '0;
		endcase
		case (state_q)
			S_FILL:         wr_addr = AW'(wc_q);
			S_CLR, S_AEND:  wr_addr = AW'(a_q);
			S_B:            wr_addr = AW'(b_q);
			S_DUP:          wr_addr = AW'(nc_q);
			S_PDUP:         wr_addr = AW'(pc_q);
			S_ADD:          wr_addr = AW'(cc_q);
			S_SHIFT:        wr_addr = AW'(j_q);
			default:        wr_addr = '0;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.sel = sel_q;
		case (state_q)
			S_LOAD: begin
				cmd.row_wr   = in_fire;
				cmd.terms_ld = in_fire && row_last;
			end
			S_FILL: cmd.fill_we = (r_q < rows) && stat.term_bit && (wc_q < DEPTH_C);
			S_CLR: cmd.used_we = (a_q < wc_q);
			S_A: cmd.a_ld = ph_q;
			S_B: begin
				if (b_q < wc_q && ph_q && stat.merge_ok) begin
					cmd.used_we = 1'b1;
					cmd.used_wd = 1'b1;
					cmd.g_ld    = 1'b1;
				end
			end
			S_DUP: cmd.next_we = (j_q >= nc_q);
			S_AEND: begin
				cmd.used_we = stat.a_used;
				cmd.used_wd = 1'b1;
			end
			S_PR: cmd.a_ld = (a_q < wc_q) && ph_q && !stat.used_bit;
			S_PDUP: cmd.prime_we = (j_q >= pc_q);
			S_COVI: cmd.cov_clr = 1'b1;
			S_ESS: cmd.cnt_clr = (r_q < rows) && stat.term_bit;
			S_ESSP: begin
				if (p_q >= pc_q) begin
					cmd.cand_last = stat.cnt_one;
				end else begin
					cmd.ess_hit = ph_q && stat.p_covers;
				end
			end
			S_ADD: cmd.cover_we = (j_q >= cc_q) && (cc_q < DEPTH_C);
			S_GR: cmd.best_clr = (r_q < rows) && stat.term_bit && !stat.covered_bit;
			S_GRP: begin
				if (p_q >= pc_q) begin
					cmd.cand_best = stat.have_best;
				end else begin
					cmd.best_try = ph_q && stat.p_covers;
				end
			end
			S_RED: cmd.oth_clr = (i_q < cc_q);
			S_REDC: cmd.oth_or = (j_q < cc_q) && ph_q && (j_q != i_q);
			S_SHIFT: begin
				if (j_inc < cc_q && ph_q) begin
					cmd.cover_we    = 1'b1;
					cmd.cover_shift = 1'b1;
				end
			end
			S_EMIT: begin
				if (cc_q == '0) begin
					cmd.out_ld    = 1'b1;
					cmd.out_empty = 1'b1;
					cmd.out_last  = 1'b1;
				end else if (ph_q) begin
					cmd.out_ld   = 1'b1;
					cmd.out_last = last_e;
				end
			end
			default: cmd.sel = sel_q;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 3'd4;
			um_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VAR_COUNT:    vc_q <= cfg_wdata;
				CFG_USE_MINTERMS: um_q <= cfg_wdata[0];
				default:          um_q <= um_q;
			endcase
		end
	end

	// Phase sequencer. Scanning states read in one cycle and use the data in the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			ph_q      <= 1'b0;
			sel_q     <= 1'b0;
			ret_q     <= 1'b0;
			row_cnt_q <= '0;
			r_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			j_q       <= '0;
			p_q       <= '0;
			i_q       <= '0;
			wc_q      <= '0;
			nc_q      <= '0;
			pc_q      <= '0;
			cc_q      <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (row_last) begin
							row_cnt_q <= '0;
							r_q       <= '0;
							wc_q      <= '0;
							pc_q      <= '0;
							state_q   <= S_FILL;
						end else begin
							row_cnt_q <= row_cnt_q + RW'(1);
						end
					end
				end
				S_FILL: begin
					if (r_q >= rows) begin
						a_q     <= '0;
						state_q <= (wc_q == '0) ? S_COVI : S_CLR;
					end else begin
						if (cmd.fill_we) begin
							wc_q <= wc_q + CW'(1);
						end
						r_q <= r_q + RW'(1);
					end
				end
				S_CLR: begin
					if (a_q >= wc_q) begin
						a_q     <= '0;
						nc_q    <= '0;
						state_q <= S_A;
					end else begin
						a_q <= a_q + CW'(1);
					end
				end
				S_A: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						b_q     <= a_q + CW'(1);
						state_q <= S_B;
					end
				end
				S_B: begin
					if (b_q >= wc_q) begin
						state_q <= S_AEND;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							if (stat.merge_ok && nc_q < DEPTH_C) begin
								j_q     <= '0;
								state_q <= S_DUP;
							end else begin
								b_q <= b_q + CW'(1);
							end
						end
					end
				end
				S_DUP: begin
					if (j_q >= nc_q) begin
						nc_q    <= nc_q + CW'(1);
						b_q     <= b_q + CW'(1);
						state_q <= S_B;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							if (stat.next_eq) begin
								b_q     <= b_q + CW'(1);
								state_q <= S_B;
							end else begin
								j_q <= j_inc;
							end
						end
					end
				end
				S_AEND: begin
					if (a_q + CW'(1) >= wc_q) begin
						a_q     <= '0;
						state_q <= S_PR;
					end else begin
						a_q     <= a_q + CW'(1);
						state_q <= S_A;
					end
				end
				S_PR: begin
					if (a_q >= wc_q) begin
						sel_q   <= !sel_q;
						wc_q    <= nc_q;
						a_q     <= '0;
						state_q <= (nc_q == '0) ? S_COVI : S_CLR;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							if (!stat.used_bit && pc_q < DEPTH_C) begin
								j_q     <= '0;
								state_q <= S_PDUP;
							end else begin
								a_q <= a_q + CW'(1);
							end
						end
					end
				end
				S_PDUP: begin
					if (j_q >= pc_q) begin
						pc_q    <= pc_q + CW'(1);
						a_q     <= a_q + CW'(1);
						state_q <= S_PR;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							if (stat.prime_eq) begin
								a_q     <= a_q + CW'(1);
								state_q <= S_PR;
							end else begin
								j_q <= j_inc;
							end
						end
					end
				end
				S_COVI: begin
					cc_q    <= '0;
					r_q     <= '0;
					state_q <= S_ESS;
				end
				S_ESS: begin
					if (r_q >= rows) begin
						r_q     <= '0;
						state_q <= S_GR;
					end else if (stat.term_bit) begin
						p_q     <= '0;
						state_q <= S_ESSP;
					end else begin
						r_q <= r_q + RW'(1);
					end
				end
				S_ESSP: begin
					if (p_q >= pc_q) begin
						if (stat.cnt_one) begin
							j_q     <= '0;
							ret_q   <= 1'b0;
							state_q <= S_ADD;
						end else begin
							r_q     <= r_q + RW'(1);
							state_q <= S_ESS;
						end
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							p_q <= p_q + CW'(1);
						end
					end
				end
				S_ADD: begin
					if (j_q >= cc_q) begin
						if (cc_q < DEPTH_C) begin
							cc_q <= cc_q + CW'(1);
						end
						r_q     <= r_q + RW'(1);
						state_q <= ret_q ? S_GR : S_ESS;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							if (stat.cover_eq) begin
								r_q     <= r_q + RW'(1);
								state_q <= ret_q ? S_GR : S_ESS;
							end else begin
								j_q <= j_inc;
							end
						end
					end
				end
				S_GR: begin
					if (r_q >= rows) begin
						i_q     <= '0;
						state_q <= S_RED;
					end else if (stat.term_bit && !stat.covered_bit) begin
						p_q     <= '0;
						state_q <= S_GRP;
					end else begin
						r_q <= r_q + RW'(1);
					end
				end
				S_GRP: begin
					if (p_q >= pc_q) begin
						if (stat.have_best) begin
							j_q     <= '0;
							ret_q   <= 1'b1;
							state_q <= S_ADD;
						end else begin
							r_q     <= r_q + RW'(1);
							state_q <= S_GR;
						end
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							p_q <= p_q + CW'(1);
						end
					end
				end
				S_RED: begin
					if (i_q >= cc_q) begin
						i_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						j_q     <= '0;
						state_q <= S_REDC;
					end
				end
				S_REDC: begin
					if (j_q >= cc_q) begin
						if (stat.redundant) begin
							j_q     <= i_q;
							state_q <= S_SHIFT;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_RED;
						end
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							j_q <= j_inc;
						end
					end
				end
				S_SHIFT: begin
					if (j_inc >= cc_q) begin
						cc_q    <= cc_q - CW'(1);
						i_q     <= '0;
						state_q <= S_RED;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							j_q <= j_inc;
						end
					end
				end
				S_EMIT: begin
					if (cc_q == '0) begin
						state_q <= S_OUT;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (stat.out_fire) begin
						if (last_e) begin
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= S_EMIT;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// The list counts never pass the RAM depth.
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wc_q <= DEPTH_C) && (nc_q <= DEPTH_C))
		else $error("work list count exceeds RAM depth");

	a_pc_cc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q <= DEPTH_C) && (cc_q <= DEPTH_C))
		else $error("prime or cover count exceeds RAM depth");

	// Delivering the final result of a cover reopens the row input.
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && stat.out_fire && last_e) |=> (state_q == S_LOAD))
		else $error("row input not reopened after the last cover term");

endmodule

// ===== src/boolean_function_minimizer_top.sv =====
// Top level of the boolean function minimizer: sequencer, datapath and stream ports.
//
// Usage:
//   Write var_count (index 0) and use_minterms (index 1) on the cfg port
//   while the block is idle. Then stream the truth table, one row per
//   input transaction in s_axis_tdata[0], row 0 first.
//   After the last row, row 2^n - 1 with n the var_count clamped to
//   1..MAX_VARS, the input stalls while the implicant lists are merged
//   and the cover is chosen; that time grows with the number of
//   implicants and primes (the merge pass compares every pair from one
//   RAM read port).
//   The cover leaves as one output transaction per term, mask in the low
//   bits of m_axis_tdata, tlast on the final term, at most 16 terms; an
//   empty cover gives one transaction with tuser set.
//   A stalled receiver holds the output register and the sequencer waits;
//   no result is dropped. The input reopens after the final result.
//   Reset restores var_count 4 and use_minterms 1 and clears the row count.
module boolean_function_minimizer_top import bfm_pkg::*; #(
	parameter int MAX_VARS = 5,
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] row_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [4:0] term_mask, [9:5] term_value
	output logic        m_axis_tuser,   // [0] empty_cover
	output logic        m_axis_tlast
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int RW = MAX_VARS + 1;

	bfm_cmd_t            cmd;
	bfm_stat_t           stat;
	logic [2:0]          n_eff;
	logic                use_minterms;
	logic [RW-1:0]       row_idx;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [MAX_VARS-1:0] out_mask, out_value;

	bfm_ctrl #(.MAX_VARS(MAX_VARS), .TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.stat(stat), .cmd(cmd), .n_eff(n_eff), .use_minterms(use_minterms),
		.row_idx(row_idx), .rd_addr(rd_addr), .wr_addr(wr_addr));

	bfm_dp #(.MAX_VARS(MAX_VARS), .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .n_eff(n_eff),
		.use_minterms(use_minterms), .row_value(s_axis_tdata[0]),
		.row_idx(row_idx), .rd_addr(rd_addr), .wr_addr(wr_addr), .stat(stat),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_mask(out_mask), .out_value(out_value),
		.out_empty(m_axis_tuser), .out_last(m_axis_tlast));

	// Pack the result fields, mask in the low bits.
	assign m_axis_tdata = {6'd0, 5'(out_value), 5'(out_mask)};

endmodule
